// ===== rtl/core/aba_pkg.sv =====
package aba_pkg;

   // sizing
   localparam int unsigned NUM_RESOURCES = 4;
   localparam int unsigned RES_W         = 2;
   localparam int unsigned ADDR_WIDTH    = 32;
   localparam int unsigned SIZE_W        = 32;
   localparam int unsigned ALIGN_W       = 16;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned DIV_CNT_W     = $clog2(ADDR_WIDTH);

   // operation codes
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // register bank select (top bit of the register index)
   localparam logic BANK_CAPACITY = 1'b0;
   localparam logic BANK_RESERVED = 1'b1;

   typedef struct packed {
      logic               func;
      logic [RES_W-1:0]   resource;
      logic [SIZE_W-1:0]  size_bytes;
      logic [ALIGN_W-1:0] alignment;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [ADDR_WIDTH-1:0] granted_address;
      logic [ADDR_WIDTH-1:0] next_free;
      logic [ADDR_WIDTH-1:0] bytes_in_use;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic align;
      logic sum;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip_div;
   } dp_status_type;

endpackage

// ===== rtl/core/aba_ctrl.sv =====
module aba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aba_pkg::dp_status_type status,
   output aba_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_ALIGN  = 5'b00100,
      ST_SUM    = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   localparam logic [aba_pkg::DIV_CNT_W-1:0] CNT_LAST = aba_pkg::DIV_CNT_W'(aba_pkg::ADDR_WIDTH - 1);

   state_type                     state_ff, state_in;
   logic [aba_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.skip_div) begin
               state_in = ST_ALIGN;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_COMMIT);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a load always enters the divide phase
   a_load_to_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DIV)
      else $error("load did not enter divide phase");

   // commit is followed by the strobe and a return to idle
   a_commit_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid && state_ff == ST_IDLE)
      else $error("commit not followed by result strobe");

   // no divide step once the datapath asked to skip
   a_skip_no_step: assert property (@(posedge clock) disable iff (reset)
      status.skip_div |-> !cmd.div_step)
      else $error("divide step while skip requested");

endmodule

// ===== rtl/core/aba_dp.sv =====
module aba_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  aba_pkg::ctrl_cmd_type               cmd,
   output aba_pkg::dp_status_type              status,
   input  aba_pkg::req_type                    req_data,
   output aba_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [aba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aba_pkg::ADDR_WIDTH-1:0]      csr_data
);

   localparam int unsigned AW = aba_pkg::ADDR_WIDTH;
   localparam int unsigned LW = aba_pkg::ALIGN_W;

   // per-resource state
   logic [AW-1:0] next_ptr_ff [aba_pkg::NUM_RESOURCES];
   logic [AW-1:0] cap_ff      [aba_pkg::NUM_RESOURCES];
   logic [AW-1:0] rsv_ff      [aba_pkg::NUM_RESOURCES];

   // request working registers
   aba_pkg::req_type req_ff;
   logic [AW-1:0]    cur_ptr_ff;
   logic [AW-1:0]    dvd_ff, dvd_in;
   logic [LW-1:0]    rem_ff, rem_in;
   logic [AW:0]      aligned_ff, aligned_in;
   logic [AW+1:0]    end_ff, end_in;
   logic             fits_ff, fits_in;
   aba_pkg::rsp_type rsp_ff, rsp_in;

   logic [LW:0]                   shifted;
   logic                          rem_ge;
   logic                          no_align;
   logic                          in_range;
   logic [aba_pkg::RES_W-1:0]     res;
   logic [aba_pkg::RES_W-1:0]     csr_res;
   logic [AW-1:0]                 cur_rsv;

   assign res      = req_ff.resource;
   assign csr_res  = csr_index[aba_pkg::RES_W-1:0];
   assign cur_rsv  = rsv_ff[res];
   assign no_align = (req_ff.alignment <= LW'(1));
   assign in_range = ({1'b0, res} < (aba_pkg::RES_W + 1)'(aba_pkg::NUM_RESOURCES));

   assign status.skip_div = no_align || (req_ff.func == aba_pkg::FUNC_RELEASE) || !in_range;

   // one restoring divide step: remainder of pointer by alignment
   assign shifted = {rem_ff, dvd_ff[AW-1]};
   assign rem_ge  = (shifted >= {1'b0, req_ff.alignment});
   assign rem_in  = rem_ge ? LW'(shifted - {1'b0, req_ff.alignment}) : shifted[LW-1:0];
   assign dvd_in  = {dvd_ff[AW-2:0], 1'b0};

   // round pointer up to the alignment
   assign aligned_in = (no_align || rem_ff == '0)
                     ? {1'b0, cur_ptr_ff}
                     : {1'b0, cur_ptr_ff} + (AW + 1)'(req_ff.alignment - rem_ff);

   // end of the new block and capacity check
   assign end_in  = {1'b0, aligned_ff} + (AW + 2)'(req_ff.size_bytes);
   assign fits_in = (end_in <= {2'b00, cap_ff[res]});

   // result formation
   always_comb begin
      rsp_in = '0;
      if (!in_range) begin
         rsp_in.status = aba_pkg::STATUS_OVERFLOW;
      end else if (req_ff.func == aba_pkg::FUNC_RELEASE) begin
         rsp_in.status    = aba_pkg::STATUS_OK;
         rsp_in.next_free = cur_rsv;
      end else if (!fits_ff) begin
         rsp_in.status       = aba_pkg::STATUS_OVERFLOW;
         rsp_in.next_free    = cur_ptr_ff;
         rsp_in.bytes_in_use = cur_ptr_ff - cur_rsv;
      end else begin
         rsp_in.status          = aba_pkg::STATUS_OK;
         rsp_in.granted_address = aligned_ff[AW-1:0];
         rsp_in.next_free       = end_ff[AW-1:0];
         rsp_in.bytes_in_use    = end_ff[AW-1:0] - cur_rsv;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req_data;
         cur_ptr_ff <= next_ptr_ff[req_data.resource];
         dvd_ff     <= next_ptr_ff[req_data.resource];
         rem_ff     <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.align) begin
         aligned_ff <= aligned_in;
      end
      if (cmd.sum) begin
         end_ff  <= end_in;
         fits_ff <= fits_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // register file and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aba_pkg::NUM_RESOURCES; i++) begin
            next_ptr_ff[i] <= '0;
            cap_ff[i]      <= '0;
            rsv_ff[i]      <= '0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index[aba_pkg::CSR_IDX_W-1] == aba_pkg::BANK_CAPACITY) begin
               cap_ff[csr_res] <= csr_data;
            end else begin
               rsv_ff[csr_res]      <= csr_data;
               next_ptr_ff[csr_res] <= csr_data;
            end
         end
         if (cmd.commit && in_range) begin
            if (req_ff.func == aba_pkg::FUNC_RELEASE) begin
               next_ptr_ff[res] <= cur_rsv;
            end else if (fits_ff) begin
               next_ptr_ff[res] <= end_ff[AW-1:0];
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

   // remainder stays below the divisor while dividing
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < req_ff.alignment)
      else $error("remainder not below alignment");

   // a granted block never starts below the pointer it came from
   a_aligned_up: assert property (@(posedge clock) disable iff (reset)
      cmd.sum |-> aligned_ff >= {1'b0, cur_ptr_ff})
      else $error("aligned address below pointer");

   // a fitting allocate moves the pointer to the block end
   a_ptr_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && in_range && req_ff.func == aba_pkg::FUNC_ALLOC && fits_ff
      |=> next_ptr_ff[res] == end_ff[AW-1:0])
      else $error("pointer not advanced after grant");

endmodule

// ===== rtl/core/aligned_bump_allocator.sv =====
// Bump-pointer allocator over four memory resources with arbitrary alignment.
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on rsp_data for a single cycle marked by rsp_valid, and it
// must be captured then since the block cannot be stalled. An allocate whose
// alignment is 2 or more first runs a 32-step restoring divider that forms the
// pointer remainder one bit per cycle; a release, or an allocate with alignment
// 0 or 1, skips the divider and moves straight on to the align step.
// busy drops in the cycle the result is shown, so a new request may be taken
// then. Registers 0..3 set the capacities, 4..7 the reserved bases; writing a
// reserved base also returns that resource's pointer to it. csr_ready is
// always high; write registers only while busy is low.
module aligned_bump_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  aba_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output aba_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [aba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [aba_pkg::ADDR_WIDTH-1:0]  csr_data
);

   aba_pkg::ctrl_cmd_type  cmd;
   aba_pkg::dp_status_type status;
   logic                   csr_write;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   aba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   aba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // an accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   // result strobe lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // overflow never grants an address
   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == aba_pkg::STATUS_OVERFLOW
      |-> rsp_data.granted_address == '0)
      else $error("overflow result with nonzero address");

endmodule

// ===== dv/aligned_bump_allocator_tb.sv =====
`timescale 1ns / 100ps

module aligned_bump_allocator_tb;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   aba_pkg::req_type                    req_data;
   logic                                rsp_valid;
   aba_pkg::rsp_type                    rsp_data;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [aba_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [aba_pkg::ADDR_WIDTH-1:0]      csr_data;

   // allocator state as the testbench sees it
   logic [aba_pkg::ADDR_WIDTH-1:0]   capacity_mirror [aba_pkg::NUM_RESOURCES];
   logic [aba_pkg::ADDR_WIDTH-1:0]   base_mirror [aba_pkg::NUM_RESOURCES];
   logic [aba_pkg::ADDR_WIDTH-1:0]   pointer_mirror [aba_pkg::NUM_RESOURCES];

   aba_pkg::rsp_type        outstanding_allocs[$];
   int                      error_count = 0;
   bit                      idle_enable = 1'b1;

   aligned_bump_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // expected result of one request, updating the mirrored pointers
   function automatic aba_pkg::rsp_type predict_allocation(input aba_pkg::req_type r);
      aba_pkg::rsp_type                  o;
      logic [aba_pkg::ADDR_WIDTH+1:0]    aligned;
      logic [aba_pkg::ADDR_WIDTH+1:0]    top;
      logic [aba_pkg::ADDR_WIDTH-1:0]    rem;
      o = '0;
      if (r.func == aba_pkg::FUNC_RELEASE) begin
         pointer_mirror[r.resource] = base_mirror[r.resource];
         o.status = aba_pkg::STATUS_OK;
         o.next_free = pointer_mirror[r.resource];
         return o;
      end
      // round the pointer up, kept wide so nothing wraps
      aligned = (aba_pkg::ADDR_WIDTH + 2)'(pointer_mirror[r.resource]);
      if (r.alignment > 16'd1) begin
         rem = pointer_mirror[r.resource] % r.alignment;
         if (rem != '0) begin
            aligned = aligned + r.alignment - rem;
         end
      end
      top = aligned + r.size_bytes;
      if (top > capacity_mirror[r.resource]) begin
         o.status = aba_pkg::STATUS_OVERFLOW;
      end else begin
         o.status = aba_pkg::STATUS_OK;
         o.granted_address = aligned[aba_pkg::ADDR_WIDTH-1:0];
         pointer_mirror[r.resource] = top[aba_pkg::ADDR_WIDTH-1:0];
      end
      o.next_free = pointer_mirror[r.resource];
      o.bytes_in_use = pointer_mirror[r.resource] - base_mirror[r.resource];
      return o;
   endfunction

   function automatic aba_pkg::req_type make_req(input logic func,
                                                 input logic [aba_pkg::RES_W-1:0] res,
                                                 input logic [aba_pkg::SIZE_W-1:0] size,
                                                 input logic [aba_pkg::ALIGN_W-1:0] align);
      aba_pkg::req_type r;
      r.func = func;
      r.resource = res;
      r.size_bytes = size;
      r.alignment = align;
      return r;
   endfunction

   // mostly small allocations, with full-range sizes and odd alignments mixed in
   function automatic aba_pkg::req_type random_req();
      aba_pkg::req_type r;
      r.func = ($urandom_range(0, 9) == 0) ? aba_pkg::FUNC_RELEASE : aba_pkg::FUNC_ALLOC;
      r.resource = aba_pkg::RES_W'($urandom_range(0, aba_pkg::NUM_RESOURCES - 1));
      r.size_bytes = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096);
      case ($urandom_range(0, 5))
         0: r.alignment = '0;
         1: r.alignment = 16'd1;
         2: r.alignment = 16'd1 << $urandom_range(1, 15);
         3: r.alignment = aba_pkg::ALIGN_W'($urandom_range(0, 65535));
         default: r.alignment = aba_pkg::ALIGN_W'($urandom_range(2, 64));
      endcase
      return r;
   endfunction

   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // one request transfer; called at a rising edge with start low
   task automatic issue_request(input aba_pkg::req_type r);
      idle_gap();
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      outstanding_allocs.push_back(predict_allocation(r));
      start <= 1'b0;
      @(posedge clock);
   endtask

   // one register write transfer
   task automatic write_reg(input logic bank, input logic [aba_pkg::RES_W-1:0] res,
                            input logic [aba_pkg::ADDR_WIDTH-1:0] value);
      idle_gap();
      csr_valid <= 1'b1;
      csr_index <= {bank, res};
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (bank == aba_pkg::BANK_CAPACITY) begin
         capacity_mirror[res] = value;
      end else begin
         base_mirror[res] = value;
         pointer_mirror[res] = value;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (outstanding_allocs.size() != 0) @(posedge clock);
   endtask

   task automatic flag_field(input string field,
                             input logic [aba_pkg::ADDR_WIDTH-1:0] want,
                             input logic [aba_pkg::ADDR_WIDTH-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      aba_pkg::rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (outstanding_allocs.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            want = outstanding_allocs.pop_front();
            flag_field("status", aba_pkg::ADDR_WIDTH'(want.status),
                       aba_pkg::ADDR_WIDTH'(rsp_data.status));
            flag_field("granted_address", want.granted_address, rsp_data.granted_address);
            flag_field("next_free", want.next_free, rsp_data.next_free);
            flag_field("bytes_in_use", want.bytes_in_use, rsp_data.bytes_in_use);
         end
      end
   end

   // zero capacities after reset: only empty allocations fit
   task automatic test_reset_state();
      for (int r = 0; r < aba_pkg::NUM_RESOURCES; r++) begin
         issue_request(make_req(aba_pkg::FUNC_ALLOC, aba_pkg::RES_W'(r), '0, '0));
      end
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd1, '0));
      issue_request(make_req(aba_pkg::FUNC_RELEASE, 2'd2, '1, '1));
      wait_drained();
   endtask

   // alignment, exact fit, wide sums, zero size, base above capacity
   task automatic test_corner_cases();
      write_reg(aba_pkg::BANK_CAPACITY, 2'd0, '1);
      write_reg(aba_pkg::BANK_CAPACITY, 2'd1, 32'd1000);
      write_reg(aba_pkg::BANK_CAPACITY, 2'd2, '0);
      write_reg(aba_pkg::BANK_CAPACITY, 2'd3, 32'h8000_0000);
      write_reg(aba_pkg::BANK_RESERVED, 2'd0, '0);
      write_reg(aba_pkg::BANK_RESERVED, 2'd1, 32'd100);
      write_reg(aba_pkg::BANK_RESERVED, 2'd2, '0);
      write_reg(aba_pkg::BANK_RESERVED, 2'd3, 32'hFFFF_FFF0);

      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd10, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd5, 16'd1));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd1, 16'd16));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd0, 16'hFFFF));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'hFFFF_FFFF, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'hFFFF_0000, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd0, 16'd2));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd0, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_RELEASE, 2'd0, '1, '1));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd900, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd0, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd1, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_RELEASE, 2'd1, '0, '0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd901, 16'd8));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd1, 32'd896, 16'd8));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd2, 32'd0, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd2, 32'd1, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd3, 32'd0, 16'd0));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd3, 32'd5, 16'h8000));
      issue_request(make_req(aba_pkg::FUNC_RELEASE, 2'd3, 32'd7, 16'd3));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd3, 16'd3));
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd1, 16'd7));
      wait_drained();

      // rewriting a base pulls the pointer back to it
      write_reg(aba_pkg::BANK_RESERVED, 2'd0, 32'd64);
      issue_request(make_req(aba_pkg::FUNC_ALLOC, 2'd0, 32'd1, 16'd0));
      wait_drained();
   endtask

   // register settings for each traffic phase
   task automatic configure_phase(input int phase);
      logic [aba_pkg::ADDR_WIDTH-1:0] cap;
      logic [aba_pkg::ADDR_WIDTH-1:0] base;
      for (int r = 0; r < aba_pkg::NUM_RESOURCES; r++) begin
         case (phase)
            1: begin
               cap = '1;
               base = (r == 0) ? '0 : (r == 1) ? 32'hFFFF_0000 :
                      (r == 2) ? '1 : 32'h7FFF_FFFF;
            end
            2: begin
               cap = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? 32'd4096 : 32'h8000_0000;
               base = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? 32'd4000 : 32'h7FFF_F000;
            end
            3: begin
               cap = $urandom;
               base = $urandom_range(0, 1) ? $urandom : (cap >> 1);
            end
            default: begin
               cap = $urandom_range(0, 1 << 20);
               base = $urandom_range(0, 4096);
            end
         endcase
         write_reg(aba_pkg::BANK_CAPACITY, aba_pkg::RES_W'(r), cap);
         write_reg(aba_pkg::BANK_RESERVED, aba_pkg::RES_W'(r), base);
      end
   endtask

   // random request stream under one register setting
   task automatic test_random_traffic(input int phase);
      configure_phase(phase);
      for (int n = 0; n < 300; n++) begin
         if (n % 50 == 0) begin
            idle_enable = (phase != 4) && ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) == 0) begin
            wait_drained();
         end
         issue_request(random_req());
      end
      wait_drained();
   endtask

   initial begin
      for (int r = 0; r < aba_pkg::NUM_RESOURCES; r++) begin
         capacity_mirror[r] = '0;
         base_mirror[r] = '0;
         pointer_mirror[r] = '0;
      end
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_corner_cases();
      for (int phase = 0; phase < 5; phase++) begin
         test_random_traffic(phase);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/aba_pkg.sv
rtl/core/aba_ctrl.sv
rtl/core/aba_dp.sv
rtl/core/aligned_bump_allocator.sv
dv/aligned_bump_allocator_tb.sv
